// ----- src/json_stream_pretty_printer_defines.svh -----
`ifndef JSON_STREAM_PRETTY_PRINTER_DEFINES_SVH
`define JSON_STREAM_PRETTY_PRINTER_DEFINES_SVH

// same-cycle implication check
`define JSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsp same-cycle check failed");

// next-cycle implication check
`define JSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsp next-cycle check failed");

`endif

// ----- src/jsp_pkg.sv -----
`timescale 1ns / 1ps
package jsp_pkg;

  localparam int MAX_DEPTH_DEF = 16;
  localparam int DEPTH_W = 5;
  localparam int SP_W = 6;
  localparam int PH_W = 5;

  localparam logic [PH_W-1:0] PH_VALUE     = 5'd0;
  localparam logic [PH_W-1:0] PH_ARR_FIRST = 5'd1;
  localparam logic [PH_W-1:0] PH_OBJ_FIRST = 5'd2;
  localparam logic [PH_W-1:0] PH_KEY       = 5'd3;
  localparam logic [PH_W-1:0] PH_COLON     = 5'd4;
  localparam logic [PH_W-1:0] PH_AFTER     = 5'd5;
  localparam logic [PH_W-1:0] PH_VSTR      = 5'd6;
  localparam logic [PH_W-1:0] PH_VESC      = 5'd7;
  localparam logic [PH_W-1:0] PH_VHEX      = 5'd8;
  localparam logic [PH_W-1:0] PH_KSTR      = 5'd9;
  localparam logic [PH_W-1:0] PH_KESC      = 5'd10;
  localparam logic [PH_W-1:0] PH_KHEX      = 5'd11;
  localparam logic [PH_W-1:0] PH_LIT_TRUE  = 5'd12;
  localparam logic [PH_W-1:0] PH_LIT_FALSE = 5'd13;
  localparam logic [PH_W-1:0] PH_LIT_NULL  = 5'd14;
  localparam logic [PH_W-1:0] PH_N_SIGN    = 5'd15;
  localparam logic [PH_W-1:0] PH_N_ZERO    = 5'd16;
  localparam logic [PH_W-1:0] PH_N_INT     = 5'd17;
  localparam logic [PH_W-1:0] PH_N_DOT     = 5'd18;
  localparam logic [PH_W-1:0] PH_N_FRAC    = 5'd19;
  localparam logic [PH_W-1:0] PH_N_EXP     = 5'd20;
  localparam logic [PH_W-1:0] PH_N_EXPSIGN = 5'd21;
  localparam logic [PH_W-1:0] PH_N_EXPDIG  = 5'd22;

  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic            comma;
    logic            nl;
    logic [SP_W-1:0] sp;
    logic            main;
    logic [7:0]      data;
    logic            trail;
    logic            status;
    logic            ok;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [2:0] lit_len(input logic [PH_W-1:0] ph);
    return (ph == PH_LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(input logic [PH_W-1:0] ph, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    if (ph == PH_LIT_TRUE) begin
      unique case (i)
        3'd0: r = "t";
        3'd1: r = "r";
        3'd2: r = "u";
        3'd3: r = "e";
        default: r = 8'h00;
      endcase
    end else if (ph == PH_LIT_FALSE) begin
      unique case (i)
        3'd0: r = "f";
        3'd1: r = "a";
        3'd2: r = "l";
        3'd3: r = "s";
        3'd4: r = "e";
        default: r = 8'h00;
      endcase
    end else begin
      unique case (i)
        3'd0: r = "n";
        3'd1: r = "u";
        3'd2: r = "l";
        3'd3: r = "l";
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- src/jsp_front.sv -----
`timescale 1ns / 1ps
module jsp_front import jsp_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       kind,
  input  logic [7:0] text_byte,
  output logic       push,
  output cmd_t       cmd
);

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [DEPTH_W-1:0] MAXD = DEPTH_W'(MAX_DEPTH);

  logic [PH_W-1:0]    ph_r, ph_nxt;
  logic [DEPTH_W-1:0] dep_r, dep_nxt;
  logic [2:0]         mc_r, mc_nxt;
  logic               err_r, err_nxt;
  logic [MAX_DEPTH-1:0] stk_r;
  logic               stk_we, stk_wd;
  logic [DEPTH_W-1:0] dep_m1;
  logic               top_obj;

  assign dep_m1  = dep_r - DEPTH_W'(1);
  assign top_obj = stk_r[dep_m1[IDX_W-1:0]];

  always_comb begin
    logic [7:0] c;
    logic fail, do_start, do_after, key, done;
    logic [PH_W-1:0] str_ph, esc_ph, hex_ph;
    c = text_byte;
    fail = 1'b0;
    do_start = 1'b0;
    do_after = 1'b0;
    key = (ph_r == PH_KSTR) || (ph_r == PH_KESC) || (ph_r == PH_KHEX);
    str_ph = key ? PH_KSTR : PH_VSTR;
    esc_ph = key ? PH_KESC : PH_VESC;
    hex_ph = key ? PH_KHEX : PH_VHEX;
    done = (ph_r == PH_AFTER) || (ph_r == PH_N_ZERO) || (ph_r == PH_N_INT) ||
           (ph_r == PH_N_FRAC) || (ph_r == PH_N_EXPDIG);
    ph_nxt = ph_r;
    dep_nxt = dep_r;
    mc_nxt = mc_r;
    err_nxt = err_r;
    stk_we = 1'b0;
    stk_wd = 1'b0;
    cmd = '0;
    cmd.data = c;
    if (accept && kind) begin
      cmd = '0;
      cmd.status = 1'b1;
      cmd.ok = !err_r && (dep_r == '0) && done;
      ph_nxt = PH_VALUE;
      dep_nxt = '0;
      mc_nxt = '0;
      err_nxt = 1'b0;
    end else if (accept && !err_r) begin
      unique case (ph_r)
        PH_VALUE: if (!is_ws(c)) do_start = 1'b1;
        PH_ARR_FIRST: begin
          if (!is_ws(c)) begin
            if (c == "]") begin
              dep_nxt = dep_m1;
              cmd.main = 1'b1;
              ph_nxt = PH_AFTER;
            end else begin
              cmd.nl = 1'b1;
              cmd.sp = {dep_r, 1'b0};
              do_start = 1'b1;
            end
          end
        end
        PH_OBJ_FIRST: begin
          if (!is_ws(c)) begin
            if (c == "}") begin
              dep_nxt = dep_m1;
              cmd.main = 1'b1;
              ph_nxt = PH_AFTER;
            end else if (c == "\"") begin
              cmd.nl = 1'b1;
              cmd.sp = {dep_r, 1'b0};
              cmd.main = 1'b1;
              ph_nxt = PH_KSTR;
            end else fail = 1'b1;
          end
        end
        PH_KEY: begin
          if (!is_ws(c)) begin
            if (c == "\"") begin
              cmd.main = 1'b1;
              ph_nxt = PH_KSTR;
            end else fail = 1'b1;
          end
        end
        PH_COLON: begin
          if (!is_ws(c)) begin
            if (c == ":") begin
              cmd.main = 1'b1;
              cmd.trail = 1'b1;
              ph_nxt = PH_VALUE;
            end else fail = 1'b1;
          end
        end
        PH_AFTER: do_after = 1'b1;
        PH_VSTR, PH_KSTR: begin
          if (c < CH_SPACE) fail = 1'b1;
          else begin
            cmd.main = 1'b1;
            if (c == "\"") ph_nxt = key ? PH_COLON : PH_AFTER;
            else if (c == "\\") ph_nxt = esc_ph;
          end
        end
        PH_VESC, PH_KESC: begin
          if (c == "u") begin
            cmd.main = 1'b1;
            mc_nxt = '0;
            ph_nxt = hex_ph;
          end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                       c == "n" || c == "r" || c == "t") begin
            cmd.main = 1'b1;
            ph_nxt = str_ph;
          end else fail = 1'b1;
        end
        PH_VHEX, PH_KHEX: begin
          if (!is_hex(c)) fail = 1'b1;
          else begin
            cmd.main = 1'b1;
            mc_nxt = mc_r + 3'd1;
            if (mc_r + 3'd1 >= 3'd4) begin
              mc_nxt = '0;
              ph_nxt = str_ph;
            end
          end
        end
        PH_LIT_TRUE, PH_LIT_FALSE, PH_LIT_NULL: begin
          if (mc_r >= lit_len(ph_r) || c != lit_char(ph_r, mc_r)) fail = 1'b1;
          else begin
            cmd.main = 1'b1;
            mc_nxt = mc_r + 3'd1;
            if (mc_r + 3'd1 >= lit_len(ph_r)) begin
              mc_nxt = '0;
              ph_nxt = PH_AFTER;
            end
          end
        end
        PH_N_SIGN: begin
          if (is_digit(c)) begin
            cmd.main = 1'b1;
            ph_nxt = (c == "0") ? PH_N_ZERO : PH_N_INT;
          end else fail = 1'b1;
        end
        PH_N_ZERO, PH_N_INT: begin
          if (is_digit(c) && ph_r == PH_N_INT) cmd.main = 1'b1;
          else if (c == ".") begin
            cmd.main = 1'b1;
            ph_nxt = PH_N_DOT;
          end else if (c == "e" || c == "E") begin
            cmd.main = 1'b1;
            ph_nxt = PH_N_EXP;
          end else begin
            ph_nxt = PH_AFTER;
            do_after = 1'b1;
          end
        end
        PH_N_DOT, PH_N_EXPSIGN: begin
          if (is_digit(c)) begin
            cmd.main = 1'b1;
            ph_nxt = (ph_r == PH_N_DOT) ? PH_N_FRAC : PH_N_EXPDIG;
          end else fail = 1'b1;
        end
        PH_N_FRAC: begin
          if (is_digit(c)) cmd.main = 1'b1;
          else if (c == "e" || c == "E") begin
            cmd.main = 1'b1;
            ph_nxt = PH_N_EXP;
          end else begin
            ph_nxt = PH_AFTER;
            do_after = 1'b1;
          end
        end
        PH_N_EXP: begin
          if (c == "+" || c == "-") begin
            cmd.main = 1'b1;
            ph_nxt = PH_N_EXPSIGN;
          end else if (is_digit(c)) begin
            cmd.main = 1'b1;
            ph_nxt = PH_N_EXPDIG;
          end else fail = 1'b1;
        end
        PH_N_EXPDIG: begin
          if (is_digit(c)) cmd.main = 1'b1;
          else begin
            ph_nxt = PH_AFTER;
            do_after = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase

      if (do_start) begin
        priority if (c == "{" || c == "[") begin
          if (dep_r >= MAXD) fail = 1'b1;
          else begin
            stk_we = 1'b1;
            stk_wd = (c == "{");
            dep_nxt = dep_r + DEPTH_W'(1);
            cmd.main = 1'b1;
            ph_nxt = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
          end
        end else if (c == "\"") begin
          cmd.main = 1'b1;
          ph_nxt = PH_VSTR;
        end else if (c == "t" || c == "f" || c == "n") begin
          cmd.main = 1'b1;
          mc_nxt = 3'd1;
          ph_nxt = (c == "t") ? PH_LIT_TRUE : ((c == "f") ? PH_LIT_FALSE : PH_LIT_NULL);
        end else if (c == "-") begin
          cmd.main = 1'b1;
          ph_nxt = PH_N_SIGN;
        end else if (is_digit(c)) begin
          cmd.main = 1'b1;
          ph_nxt = (c == "0") ? PH_N_ZERO : PH_N_INT;
        end else fail = 1'b1;
      end

      if (do_after && !is_ws(c)) begin
        if (dep_r == '0) fail = 1'b1;
        else if (c == (top_obj ? "}" : "]")) begin
          dep_nxt = dep_m1;
          cmd.nl = 1'b1;
          cmd.sp = {dep_m1, 1'b0};
          cmd.main = 1'b1;
          ph_nxt = PH_AFTER;
        end else if (c == ",") begin
          cmd.comma = 1'b1;
          cmd.nl = 1'b1;
          cmd.sp = {dep_r, 1'b0};
          ph_nxt = top_obj ? PH_KEY : PH_VALUE;
        end else fail = 1'b1;
      end

      if (fail) begin
        err_nxt = 1'b1;
        cmd = '0;
        stk_we = 1'b0;
      end
    end
  end

  assign push = accept && (cmd.comma || cmd.nl || cmd.main || cmd.trail || cmd.status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_VALUE;
      dep_r <= '0;
      mc_r  <= '0;
      err_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      dep_r <= dep_nxt;
      mc_r  <= mc_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_r[dep_r[IDX_W-1:0]] <= stk_wd;
  end

endmodule

// ----- src/jsp_cmd_fifo.sv -----
`timescale 1ns / 1ps
module jsp_cmd_fifo import jsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic nonempty,
  output logic full
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign rdata    = mem_r[rp_r];
  assign nonempty = (cnt_r != 2'd0);
  assign full     = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// ----- src/jsp_back.sv -----
`timescale 1ns / 1ps
module jsp_back import jsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_status,
  output logic       text_ok,
  output logic       last_of_run
);

  cmd_t       w_r, rem;
  logic       busy_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       stat_r, ok_r, last_r;
  logic [7:0] e_byte;
  logic       e_stat, last, load, emit;

  always_comb begin
    rem = w_r;
    e_byte = 8'h00;
    e_stat = 1'b0;
    priority if (w_r.comma) begin
      e_byte = ",";
      rem.comma = 1'b0;
    end else if (w_r.nl) begin
      e_byte = 8'h0a;
      rem.nl = 1'b0;
    end else if (w_r.sp != '0) begin
      e_byte = CH_SPACE;
      rem.sp = w_r.sp - SP_W'(1);
    end else if (w_r.main) begin
      e_byte = w_r.data;
      rem.main = 1'b0;
    end else if (w_r.trail) begin
      e_byte = CH_SPACE;
      rem.trail = 1'b0;
    end else begin
      e_stat = 1'b1;
      rem.status = 1'b0;
    end
    last = !(rem.comma || rem.nl || (rem.sp != '0) || rem.main || rem.trail || rem.status);
  end

  assign load = !out_valid_r || out_ready;
  assign emit = busy_r && load;
  assign pop  = head_valid && (!busy_r || (emit && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) busy_r <= 1'b1;
      else if (emit && last) busy_r <= 1'b0;
      if (load) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) w_r <= head;
    else if (emit) w_r <= rem;
    if (emit) begin
      byte_r <= e_byte;
      stat_r <= e_stat;
      ok_r   <= e_stat && w_r.ok;
      last_r <= last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = byte_r;
  assign is_status   = stat_r;
  assign text_ok     = ok_r;
  assign last_of_run = last_r;

endmodule

// ----- src/json_stream_pretty_printer.sv -----
// path: command queue, back-end work register, then output register
// throughput: one input beat per cycle while in_ready is high; a beat that
// makes an indentation run of n bytes keeps the output busy while they go out,
// and the 2-entry command queue then fills and stalls the input
// reset: synchronous active-low rst_n clears parser state, queue and output valid
`timescale 1ns / 1ps
`include "json_stream_pretty_printer_defines.svh"
module json_stream_pretty_printer import jsp_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_is_status,
  output logic       out_text_ok,
  output logic       out_last_of_run
);

  logic accept, push, pop, nonempty, full;
  cmd_t cmd, head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  jsp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .kind(in_kind),
    .text_byte(in_text_byte), .push(push), .cmd(cmd)
  );

  jsp_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(cmd), .pop(pop),
    .rdata(head), .nonempty(nonempty), .full(full)
  );

  jsp_back u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(nonempty), .head(head), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_out_byte),
    .is_status(out_is_status), .text_ok(out_text_ok), .last_of_run(out_last_of_run)
  );

  `JSP_ASSERT_NOW(a_no_push_full, push, !full)
  `JSP_ASSERT_NOW(a_status_form, out_valid && out_is_status,
                  out_out_byte == 8'h00 && out_last_of_run)
  `JSP_ASSERT_NOW(a_ok_only_status, out_valid && !out_is_status, !out_text_ok)
  `JSP_ASSERT_NEXT(a_end_queued, accept && in_kind, nonempty)

endmodule

// ----- tb/sv/json_stream_pretty_printer_tb.sv -----
`timescale 1ns / 1ps
module json_stream_pretty_printer_tb;
  import jsp_pkg::*;

  localparam int LIMIT = 400000;
  localparam int MAXD = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [7:0] in_text_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic out_is_status;
  logic out_text_ok;
  logic out_last_of_run;

  json_stream_pretty_printer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_text_byte(in_text_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_out_byte(out_out_byte), .out_is_status(out_is_status),
    .out_text_ok(out_text_ok), .out_last_of_run(out_last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic       kind;
    logic [7:0] b;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       ok;
    logic       last;
  } fmt_beat_t;

  text_beat_t pending_q[$];
  fmt_beat_t  fmt_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit pause_send = 1'b0;

  // shadow parser state
  logic [PH_W-1:0] ph;
  logic [4:0] depth;
  logic kinds [MAXD];
  logic [2:0] mcnt;
  logic err;
  logic [7:0] obuf[$];

  function automatic bit ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction
  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit hexd(logic [7:0] c);
    return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  task automatic put(logic [7:0] c);
    if (obuf.size() < 2 * MAXD + 4) obuf.insert(obuf.size(), c);
  endtask
  task automatic flag_err();
    err = 1'b1;
    obuf.delete();
  endtask
  task automatic nl_indent(int d);
    put(8'h0a);
    for (int i = 0; i < 2 * d; i++) put(CH_SPACE);
  endtask
  task automatic open_c(logic obj, logic [7:0] c);
    if (depth >= MAXD) begin
      flag_err();
      return;
    end
    kinds[depth] = obj;
    depth++;
    put(c);
    ph = obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
  endtask
  task automatic begin_value(logic [7:0] c);
    if (c == "\"") begin put(c); ph = PH_VSTR; end
    else if (c == "{") open_c(1'b1, c);
    else if (c == "[") open_c(1'b0, c);
    else if (c == "t") begin put(c); mcnt = 3'd1; ph = PH_LIT_TRUE; end
    else if (c == "f") begin put(c); mcnt = 3'd1; ph = PH_LIT_FALSE; end
    else if (c == "n") begin put(c); mcnt = 3'd1; ph = PH_LIT_NULL; end
    else if (c == "-") begin put(c); ph = PH_N_SIGN; end
    else if (c == "0") begin put(c); ph = PH_N_ZERO; end
    else if (c >= "1" && c <= "9") begin put(c); ph = PH_N_INT; end
    else flag_err();
  endtask
  task automatic begin_key(logic [7:0] c);
    if (c == "\"") begin put(c); ph = PH_KSTR; end
    else flag_err();
  endtask
  task automatic past_value(logic [7:0] c);
    logic obj;
    if (ws(c)) return;
    if (depth == 5'd0) begin
      flag_err();
      return;
    end
    obj = kinds[depth-1];
    if (c == (obj ? "}" : "]")) begin
      depth--;
      nl_indent(depth);
      put(c);
      ph = PH_AFTER;
    end else if (c == ",") begin
      put(c);
      nl_indent(depth);
      ph = obj ? PH_KEY : PH_VALUE;
    end else flag_err();
  endtask
  task automatic str_byte(logic [7:0] c, bit key);
    logic [PH_W-1:0] s, e;
    s = key ? PH_KSTR : PH_VSTR;
    e = key ? PH_KESC : PH_VESC;
    if (ph == s) begin
      if (c < 8'h20) begin flag_err(); return; end
      put(c);
      if (c == "\"") ph = key ? PH_COLON : PH_AFTER;
      else if (c == "\\") ph = e;
    end else if (ph == e) begin
      if (c == "u") begin put(c); mcnt = 3'd0; ph = key ? PH_KHEX : PH_VHEX; end
      else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t") begin put(c); ph = s; end
      else flag_err();
    end else begin
      if (!hexd(c)) begin flag_err(); return; end
      put(c);
      mcnt++;
      if (mcnt >= 3'd4) begin mcnt = 3'd0; ph = s; end
    end
  endtask
  task automatic lit_byte(logic [7:0] c);
    string w;
    if (ph == PH_LIT_TRUE) w = "true";
    else if (ph == PH_LIT_FALSE) w = "false";
    else w = "null";
    if (mcnt >= w.len() || c != w[mcnt]) begin flag_err(); return; end
    put(c);
    mcnt++;
    if (mcnt >= w.len()) begin mcnt = 3'd0; ph = PH_AFTER; end
  endtask
  task automatic num_byte(logic [7:0] c);
    bit d, e;
    d = dig(c);
    e = (c == "e" || c == "E");
    case (ph)
      PH_N_SIGN: begin
        if (c == "0") begin put(c); ph = PH_N_ZERO; end
        else if (d) begin put(c); ph = PH_N_INT; end
        else flag_err();
        return;
      end
      PH_N_ZERO, PH_N_INT: begin
        if (d && ph == PH_N_INT) begin put(c); return; end
        if (c == ".") begin put(c); ph = PH_N_DOT; return; end
        if (e) begin put(c); ph = PH_N_EXP; return; end
      end
      PH_N_DOT: begin
        if (d) begin put(c); ph = PH_N_FRAC; end else flag_err();
        return;
      end
      PH_N_FRAC: begin
        if (d) begin put(c); return; end
        if (e) begin put(c); ph = PH_N_EXP; return; end
      end
      PH_N_EXP: begin
        if (c == "+" || c == "-") begin put(c); ph = PH_N_EXPSIGN; end
        else if (d) begin put(c); ph = PH_N_EXPDIG; end
        else flag_err();
        return;
      end
      PH_N_EXPSIGN: begin
        if (d) begin put(c); ph = PH_N_EXPDIG; end else flag_err();
        return;
      end
      default: begin
        if (d) begin put(c); return; end
      end
    endcase
    ph = PH_AFTER;
    past_value(c);
  endtask

  task automatic clear_parser();
    ph = PH_VALUE;
    depth = 5'd0;
    mcnt = 3'd0;
    err = 1'b0;
  endtask

  task automatic predict_format(text_beat_t t);
    fmt_beat_t r;
    bit done;
    obuf.delete();
    if (t.kind) begin
      done = ph == PH_AFTER || ph == PH_N_ZERO || ph == PH_N_INT ||
             ph == PH_N_FRAC || ph == PH_N_EXPDIG;
      r = '{8'h00, 1'b1, (!err && depth == 5'd0 && done), 1'b1};
      fmt_q.insert(fmt_q.size(), r);
      clear_parser();
      return;
    end
    if (!err) begin
      case (ph)
        PH_VALUE: if (!ws(t.b)) begin_value(t.b);
        PH_ARR_FIRST: if (!ws(t.b)) begin
          if (t.b == "]") begin depth--; put(t.b); ph = PH_AFTER; end
          else begin nl_indent(depth); begin_value(t.b); end
        end
        PH_OBJ_FIRST: if (!ws(t.b)) begin
          if (t.b == "}") begin depth--; put(t.b); ph = PH_AFTER; end
          else begin nl_indent(depth); begin_key(t.b); end
        end
        PH_KEY: if (!ws(t.b)) begin_key(t.b);
        PH_COLON: if (!ws(t.b)) begin
          if (t.b == ":") begin put(":"); put(CH_SPACE); ph = PH_VALUE; end
          else flag_err();
        end
        PH_AFTER: past_value(t.b);
        PH_VSTR, PH_VESC, PH_VHEX: str_byte(t.b, 1'b0);
        PH_KSTR, PH_KESC, PH_KHEX: str_byte(t.b, 1'b1);
        PH_LIT_TRUE, PH_LIT_FALSE, PH_LIT_NULL: lit_byte(t.b);
        PH_N_SIGN, PH_N_ZERO, PH_N_INT, PH_N_DOT, PH_N_FRAC, PH_N_EXP,
        PH_N_EXPSIGN, PH_N_EXPDIG: num_byte(t.b);
        default: flag_err();
      endcase
    end
    for (int k = 0; k < obuf.size(); k++) begin
      r = '{obuf[k], 1'b0, 1'b0, (k == obuf.size() - 1)};
      fmt_q.insert(fmt_q.size(), r);
    end
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_q.insert(pending_q.size(), '{1'b0, s[i]});
  endtask
  task automatic push_end();
    pending_q.insert(pending_q.size(), '{1'b1, 8'($urandom)});
  endtask

  // driver: bursts and gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_format('{in_kind, in_text_byte});
        void'(pending_q.pop_front());
      end
      if (in_valid && !in_ready) begin
      end else if (pause_send || pending_q.size() == 0 ||
                   (in_valid && in_ready && pending_q.size() == 0)) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_kind <= pending_q[0].kind;
        in_text_byte <= pending_q[0].b;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? $urandom_range(6, 1) : 0;
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // receiver: stalls on a pattern, plus long hold-off
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else begin
      case (cycles % 64 / 16)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3, 0) != 0);
        2: out_ready <= ($urandom_range(1, 0) != 0);
        default: out_ready <= ($urandom_range(4, 0) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    fmt_beat_t x;
    if (rst_n && out_valid && out_ready) begin
      if (fmt_q.size() == 0) begin
        $display("%0t: unexpected beat byte=%h st=%b ok=%b last=%b", $time,
                 out_out_byte, out_is_status, out_text_ok, out_last_of_run);
        errors++;
      end else begin
        x = fmt_q.pop_front();
        if (x != {out_out_byte, out_is_status, out_text_ok, out_last_of_run}) begin
          $display({"%0t: mismatch expected byte=%h st=%b ok=%b last=%b",
                    " actual byte=%h st=%b ok=%b last=%b"},
                   $time, x.b, x.st, x.ok, x.last, out_out_byte, out_is_status,
                   out_text_ok, out_last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic string rand_json(int lvl);
    string s, ws_s;
    int n;
    if ($urandom_range(3, 0) == 0) ws_s = " \t\r\n";
    else ws_s = "";
    case ($urandom_range(lvl > 3 ? 6 : 8, 0))
      0: return "true";
      1: return "false";
      2: return "null";
      3: return $sformatf("-%0d.%0de+%0d", $urandom_range(99, 0), $urandom_range(9, 0),
                          $urandom_range(9, 0));
      4: return $sformatf("%0dE-3", $urandom_range(500, 0));
      5: return "\"a\\u0Af9\\n~\"";
      6: return "0";
      7: begin
        n = $urandom_range(3, 0);
        s = {"[", ws_s};
        for (int i = 0; i < n; i++) begin
          if (i > 0) s = {s, ","};
          s = {s, rand_json(lvl + 1)};
        end
        return {s, ws_s, "]"};
      end
      default: begin
        n = $urandom_range(3, 0);
        s = "{";
        for (int i = 0; i < n; i++) begin
          if (i > 0) s = {s, ", "};
          s = {s, $sformatf("\"k%0d\" :", i), rand_json(lvl + 1)};
        end
        return {s, "}"};
      end
    endcase
  endfunction

  initial begin
    string s;
    int c;
    clear_parser();
    push_text("{\"a\":[1,-0.5e+3,true],\"b\":{},\"c\":[]}");
    push_end();
    push_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\uAbC9\"");
    push_end();
    push_text("[[[[[[[[[[[[[[[[[");
    push_end();
    push_text("null 1");
    push_end();
    push_text("\"\001\"");
    push_end();
    pending_q.insert(pending_q.size(), '{1'b0, 8'hff});
    push_end();
    push_text("[");
    push_end();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // long hold-off while sender keeps offering
    hold_off = 1'b1;
    wait (hold_cnt >= 300);
    hold_off = 1'b0;
    wait (pending_q.size() == 0 && fmt_q.size() == 0);
    pause_send = 1'b1;
    repeat (20) @(posedge clk);
    pause_send = 1'b0;
    c = 0;
    while (c < 60) begin
      if ($urandom_range(4, 0) == 0) begin
        s = rand_json(0);
        for (int i = 0; i < s.len(); i++) begin
          if ($urandom_range(15, 0) == 0) s[i] = 8'($urandom);
        end
      end else s = rand_json(0);
      if ($urandom_range(9, 0) == 0)
        for (int i = 0; i < 17; i++) s = {"[", s};
      push_text(s);
      push_end();
      c += s.len() + 1;
    end
    for (int i = 0; i < 256; i += 8) begin
      pending_q.insert(pending_q.size(), '{1'b0, 8'(i)});
      if (i % 64 == 56) push_end();
    end
    push_end();
    wait (pending_q.size() == 0 && !in_valid && fmt_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && fmt_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
